/* design/cdc4s_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and sigmoid table builder for the conv4 silu block
package cdc4s_pkg;

  localparam int unsigned TAPS = 4;
  localparam int unsigned WEIGHT_WIDTH = 16;
  localparam int unsigned RESULT_WIDTH = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_WEIGHT_OLDEST = 2'd0,
    CFG_WEIGHT_SECOND = 2'd1,
    CFG_WEIGHT_THIRD  = 2'd2,
    CFG_WEIGHT_NEWEST = 2'd3
  } cfg_index_t;

  typedef logic [WEIGHT_WIDTH-1:0] weight_t;
  typedef weight_t [TAPS-1:0] weights_t;

  typedef struct packed {
    logic signed [RESULT_WIDTH-1:0] activated;
    logic                           clipped;
  } result_t;

  localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

  // shift-subtract division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // q0.16 sigmoid at the centre of bin i of n over [-8,8)
  function automatic logic [15:0] sig_entry(input int unsigned i, input int unsigned n);
    logic [63:0] off;
    logic [63:0] a;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] u3;
    logic [63:0] u4;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] r;
    logic        nonneg;
    off    = udiv64(((64'(i) << 1) + 64'd1) << 31, 64'(n));
    nonneg = off >= ONE_Q31;
    a      = nonneg ? off - ONE_Q31 : ONE_Q31 - off;
    u      = a >> 5;
    u2     = (u * u) >> 31;
    u3     = (u2 * u) >> 31;
    u4     = (u3 * u) >> 31;
    e      = ONE_Q31 - u + (u2 >> 1) - (u3 / 64'd6) + (u4 / 64'd24);
    for (int k = 0; k < 8; k++) begin
      e = ((e * e) + (ONE_Q31 >> 1)) >> 31;
    end
    num = nonneg ? ONE_Q31 : e;
    den = ONE_Q31 + e;
    r   = udiv64((num << 16) + (den >> 1), den);
    return (r > 64'd65535) ? 16'hffff : r[15:0];
  endfunction

endpackage

/* design/causal_depthwise_conv4_silu.sv */
`timescale 1ns / 1ps
// top level: four-tap causal depthwise convolution with fixed-point silu
// throughput: one word per cycle, set by the credit between issue and the result queue
// each word runs through products, sum and round, index, table read, product, saturate
// reset: synchronous, clears weights, sample history and both queues
module causal_depthwise_conv4_silu
  import cdc4s_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH    = 16,
  parameter int unsigned SIGMOID_ENTRIES = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [RESULT_WIDTH-1:0]   activated,
  output logic                             clipped,
  input  logic                             cfg_wen,
  input  logic [CFG_INDEX_WIDTH-1:0]       cfg_index,
  input  logic [WEIGHT_WIDTH-1:0]          cfg_data
);

  typedef logic [4*SAMPLE_WIDTH-1:0] taps_t;

  weights_t weights;
  taps_t    taps_in;
  taps_t    taps_out;
  logic     taps_push;
  logic     taps_full;
  logic     taps_empty;
  logic     taps_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights <= '0;
    end else if (cfg_wen) begin
      case (cfg_index_t'(cfg_index))
        CFG_WEIGHT_OLDEST: weights[CFG_WEIGHT_OLDEST] <= cfg_data;
        CFG_WEIGHT_SECOND: weights[CFG_WEIGHT_SECOND] <= cfg_data;
        CFG_WEIGHT_THIRD:  weights[CFG_WEIGHT_THIRD]  <= cfg_data;
        CFG_WEIGHT_NEWEST: weights[CFG_WEIGHT_NEWEST] <= cfg_data;
        default:           weights <= weights;
      endcase
    end
  end

  cdc4s_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .sample   (sample),
    .full     (full),
    .taps_push(taps_push),
    .taps     (taps_in),
    .taps_full(taps_full)
  );

  cdc4s_fifo #(
    .item_t(taps_t),
    .DEPTH (2)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (taps_push),
    .din  (taps_in),
    .full (taps_full),
    .pop  (taps_pop),
    .dout (taps_out),
    .empty(taps_empty)
  );

  cdc4s_back #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .SIGMOID_ENTRIES(SIGMOID_ENTRIES),
    .OUT_DEPTH      (8)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .weights   (weights),
    .taps      (taps_out),
    .taps_empty(taps_empty),
    .taps_pop  (taps_pop),
    .activated (activated),
    .clipped   (clipped),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

/* design/cdc4s_fifo.sv */
`timescale 1ns / 1ps
// small register queue used between and after the front and back parts
module cdc4s_fifo #(
  parameter type item_t = logic [7:0],
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output item_t dout,
  output logic  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

/* design/cdc4s_front.sv */
`timescale 1ns / 1ps
// front part: takes samples, keeps the three previous ones, forms tap words
module cdc4s_front #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                         full,
  output logic                         taps_push,
  output logic [4*SAMPLE_WIDTH-1:0]    taps,
  input  logic                         taps_full
);

  logic [SAMPLE_WIDTH-1:0] history [3];
  logic                    accept;

  assign full      = taps_full;
  assign accept    = push && !taps_full;
  assign taps_push = accept;
  // oldest in the low slice
  assign taps      = {sample, history[2], history[1], history[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      history[0] <= '0;
      history[1] <= '0;
      history[2] <= '0;
    end else if (accept) begin
      history[0] <= history[1];
      history[1] <= history[2];
      history[2] <= sample;
    end
  end

endmodule

/* design/cdc4s_back.sv */
`timescale 1ns / 1ps
// back part: dot product, rounding, sigmoid lookup, product and saturation
module cdc4s_back
  import cdc4s_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH    = 16,
  parameter int unsigned SIGMOID_ENTRIES = 256,
  parameter int unsigned OUT_DEPTH       = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  weights_t                         weights,
  input  logic [4*SAMPLE_WIDTH-1:0]        taps,
  input  logic                             taps_empty,
  output logic                             taps_pop,
  output logic signed [RESULT_WIDTH-1:0]   activated,
  output logic                             clipped,
  output logic                             empty,
  input  logic                             pop
);

  localparam int unsigned W   = SAMPLE_WIDTH;
  localparam int unsigned PRW = W + WEIGHT_WIDTH;
  localparam int unsigned AW  = W + 18;
  localparam int unsigned SW  = W + 4;
  localparam int unsigned SXW = (SW > 17) ? SW : 17;
  localparam int unsigned IW  = $clog2(SIGMOID_ENTRIES);
  localparam int unsigned MW  = SW + 17;
  localparam int unsigned RW  = W + 5;
  localparam int unsigned RXW = (RW > 17) ? RW : 17;
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);

  logic [15:0] sig_rom [SIGMOID_ENTRIES];

  for (genvar i = 0; i < SIGMOID_ENTRIES; i++) begin : g_rom
    assign sig_rom[i] = sig_entry(i, SIGMOID_ENTRIES);
  end

  logic                  v1, v2, v3, v4, v5;
  logic signed [PRW-1:0] prod1 [TAPS];
  logic signed [SW-1:0]  s2, s3, s4;
  logic [IW-1:0]         idx3;
  logic [15:0]           sig4;
  logic signed [MW-1:0]  p5;
  logic [OCW-1:0]        occ;
  logic                  issue;
  logic                  out_pop;
  logic                  out_empty;

  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  acc_rnd;
  logic signed [SXW-1:0] s_ext;
  logic [15:0]           c16;
  logic [16+IW:0]        idx_mul;
  logic signed [MW-1:0]  p_rnd;
  logic signed [RW-1:0]  r;
  logic signed [RXW-1:0] r_ext;
  result_t               res;
  result_t               out_word;

  // credit: queue entries plus words in flight
  assign issue    = !taps_empty && (occ < OCW'(OUT_DEPTH));
  assign taps_pop = issue;
  assign out_pop  = pop && !out_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
    end else begin
      occ <= occ + OCW'(issue) - OCW'(out_pop);
      v1  <= issue;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < TAPS; k++) begin
      acc = acc + AW'(prod1[k]);
    end
    acc_rnd = acc + AW'(1 << 13);
  end

  always_comb begin
    s_ext = SXW'(s2);
    if (s_ext > SXW'(32767)) begin
      c16 = 16'h7fff;
    end else if (s_ext < -SXW'(32768)) begin
      c16 = 16'h8000;
    end else begin
      c16 = s_ext[15:0];
    end
    idx_mul = {~c16[15], c16[14:0]} * (IW + 1)'(SIGMOID_ENTRIES);
  end

  always_comb begin
    p_rnd = p5 + MW'(1 << 15);
    r     = p_rnd[MW-1:16];
    r_ext = RXW'(r);
    res.clipped = 1'b0;
    if (r_ext > RXW'(32767)) begin
      res.activated = 16'sh7fff;
      res.clipped   = 1'b1;
    end else if (r_ext < -RXW'(32768)) begin
      res.activated = -16'sh8000;
      res.clipped   = 1'b1;
    end else begin
      res.activated = r_ext[15:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < TAPS; k++) begin
      prod1[k] <= $signed(taps[k*W +: W]) * $signed(weights[k]);
    end
    s2   <= acc_rnd[AW-1:14];
    s3   <= s2;
    idx3 <= idx_mul[16 +: IW];
    s4   <= s3;
    sig4 <= sig_rom[idx3];
    p5   <= s4 * $signed({1'b0, sig4});
  end

  cdc4s_fifo #(
    .item_t(result_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (v5),
    .din  (res),
    .full (),
    .pop  (pop),
    .dout (out_word),
    .empty(out_empty)
  );

  assign empty     = out_empty;
  assign activated = out_word.activated;
  assign clipped   = out_word.clipped;

endmodule

/* design/cdc4s_checker.sv */
`timescale 1ns / 1ps
// port-level checker for the conv4 silu block and its bind
module cdc4s_checker
  import cdc4s_pkg::*;
(
  input logic                           clk,
  input logic                           rst,
  input logic                           push,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic signed [RESULT_WIDTH-1:0] activated,
  input logic                           clipped
);

  logic [4:0] outstanding;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 5'(in_acc) - 5'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_no_invented_word: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> outstanding != '0)
    else $error("result word without a matching sample");

  a_held_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(activated) && $stable(clipped))
    else $error("waiting result word changed");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    (!empty && clipped) |-> (activated == 16'sh7fff || activated == -16'sh8000))
    else $error("clipped word not at a range limit");

endmodule

bind causal_depthwise_conv4_silu cdc4s_checker u_checker (.*);
